/* design/fde_pkg.sv */
// Shared types, constants and arithmetic helpers for the feedback delay echo.
`timescale 1ns / 1ps

package fde_pkg;

  // Block dimensions.
  localparam int CHANNELS    = 8;
  localparam int MAX_DELAY   = 65536;
  localparam int SAMPLE_BITS = 24;

  // Fixed field and register widths.
  localparam int CH_BITS       = 3;
  localparam int GAIN_BITS     = 18;
  localparam int LEN_BITS      = 17;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 18;

  // Derived widths.
  localparam int POS_BITS  = $clog2(MAX_DELAY);
  localparam int ADDR_BITS = CH_BITS + POS_BITS;
  localparam int MEM_DEPTH = 2 ** ADDR_BITS;
  localparam int PROD_BITS = GAIN_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + 1;
  localparam int Q_BITS    = ACC_BITS + 1 - FRAC_BITS;

  // Queue sizes between the parts of the block.
  localparam int CMDQ_DEPTH    = 2;
  localparam int CMDQ_PTR_BITS = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_PTR_BITS = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

  // Register reset values.
  localparam logic [LEN_BITS-1:0]         DELAY_LENGTH_RST  = LEN_BITS'(4800);
  localparam logic signed [GAIN_BITS-1:0] FEEDBACK_GAIN_RST = GAIN_BITS'(13107);
  localparam logic signed [GAIN_BITS-1:0] WET_LEVEL_RST     = GAIN_BITS'(65536);
  localparam logic signed [GAIN_BITS-1:0] DRY_LEVEL_RST     = GAIN_BITS'(65536);

  // Rounding and saturation constants.
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam logic signed [Q_BITS-1:0] Q_MAX =
    Q_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_BITS-1:0] Q_MIN =
    Q_BITS'(-(longint'(1) << (SAMPLE_BITS - 1)));

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;

  localparam sample_t SAMPLE_MAX = SAMPLE_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN = SAMPLE_BITS'(-(longint'(1) << (SAMPLE_BITS - 1)));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELAY_LENGTH  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_WET_LEVEL     = 2'd2,
    REG_DRY_LEVEL     = 2'd3
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    logic [CH_BITS-1:0] channel;
    sample_t            sample_in;
  } in_item_t;

  // Result item.
  typedef struct packed {
    sample_t            sample_out;
    logic [CH_BITS-1:0] out_channel;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [CH_BITS-1:0]   ch;
    sample_t              x;
    logic [ADDR_BITS-1:0] addr;
    logic                 ch_ok;
    logic                 written;
  } cmd_t;

  // Gain settings seen by the datapath.
  typedef struct packed {
    gain_t fb;
    gain_t wet;
    gain_t dry;
  } gains_t;

  // A length of zero acts as one, a length above the store acts as the store size.
  function automatic logic [LEN_BITS-1:0] eff_length(input logic [LEN_BITS-1:0] len);
    logic [LEN_BITS-1:0] r;
    if (len == '0) begin
      r = LEN_BITS'(1);
    end else if (32'(len) > MAX_DELAY) begin
      r = LEN_BITS'(MAX_DELAY);
    end else begin
      r = len;
    end
    return r;
  endfunction

  // Round a Q.16 sum to nearest (half up), then saturate to the sample width.
  function automatic sample_t round_sat(input logic signed [ACC_BITS-1:0] v);
    logic [ACC_BITS:0]         t;
    logic signed [Q_BITS-1:0]  q;
    sample_t                   r;
    t = {v[ACC_BITS-1], v} + (ACC_BITS + 1)'(ROUND_HALF);
    q = $signed(t[ACC_BITS:FRAC_BITS]);
    if (q > Q_MAX) begin
      r = SAMPLE_MAX;
    end else if (q < Q_MIN) begin
      r = SAMPLE_MIN;
    end else begin
      r = q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* design/fde_front.sv */
// Front end: accepts items, tracks ring positions and fill counts, builds commands.
`timescale 1ns / 1ps

module fde_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  fde_pkg::in_item_t              in_item,
  input  logic                           q_full,
  input  logic [fde_pkg::LEN_BITS-1:0]   len_eff,
  input  logic                           len_wr,
  output logic                           q_push,
  output fde_pkg::cmd_t                  q_cmd
);

  // Per-channel ring position and count of entries written since reset.
  logic [fde_pkg::POS_BITS-1:0] pos_r  [fde_pkg::CHANNELS];
  logic [fde_pkg::LEN_BITS-1:0] fill_r [fde_pkg::CHANNELS];

  logic [fde_pkg::CH_BITS-1:0]  ch;
  logic                         ch_ok;
  logic                         accept;
  logic [fde_pkg::POS_BITS-1:0] pos_use;
  logic [fde_pkg::LEN_BITS-1:0] pos_inc;
  logic [fde_pkg::LEN_BITS-1:0] pos_adv;
  logic                         written;

  assign ch     = in_item.channel;
  assign ch_ok  = (32'(ch) < fde_pkg::CHANNELS);
  assign accept = in_push & ~q_full;
  assign q_push = accept;

  // Position lookup, wrap and written check for the incoming item.
  always_comb begin
    pos_use = pos_r[ch];
    if (fde_pkg::LEN_BITS'(pos_use) >= len_eff) begin
      pos_use = '0;
    end
    pos_inc = fde_pkg::LEN_BITS'(pos_use) + fde_pkg::LEN_BITS'(1);
    pos_adv = (pos_inc >= len_eff) ? '0 : pos_inc;
    written = ch_ok && (fde_pkg::LEN_BITS'(pos_use) < fill_r[ch]);
  end

  // Command for the back end.
  always_comb begin
    q_cmd.ch      = ch;
    q_cmd.x       = in_item.sample_in;
    q_cmd.addr    = {ch, pos_use};
    q_cmd.ch_ok   = ch_ok;
    q_cmd.written = written;
  end

  // Written entries always form a prefix of each ring, so one count per channel
  // tells which entries still hold their reset value of zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fde_pkg::CHANNELS; i++) begin
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
      end
    end else if (len_wr) begin
      for (int i = 0; i < fde_pkg::CHANNELS; i++) begin
        pos_r[i] <= '0;
      end
    end else if (accept && ch_ok) begin
      pos_r[ch] <= pos_adv[fde_pkg::POS_BITS-1:0];
      if (!written) begin
        fill_r[ch] <= pos_inc;
      end
    end
  end

  // The ring position is always inside the current length.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ch_ok) |-> (fde_pkg::LEN_BITS'(pos_r[ch]) < len_eff))
    else $error("ring position outside the delay length");

  // A position never runs ahead of the written prefix.
  a_pos_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ch_ok) |-> (fde_pkg::LEN_BITS'(pos_r[ch]) <= fill_r[ch]))
    else $error("ring position beyond written entries");

  // A length write returns the ring position of channel 0 to zero.
  a_len_wr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    len_wr |=> (pos_r[0] == '0))
    else $error("length write did not clear ring position");

endmodule

/* design/fde_cmd_queue.sv */
// Short queue of classified items between the front and the back end.
`timescale 1ns / 1ps

module fde_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fde_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output fde_pkg::cmd_t head
);

  fde_pkg::cmd_t                     slot_r [fde_pkg::CMDQ_DEPTH];
  logic [fde_pkg::CMDQ_PTR_BITS-1:0] wr_ptr_r;
  logic [fde_pkg::CMDQ_PTR_BITS-1:0] rd_ptr_r;
  logic [fde_pkg::CMDQ_CNT_BITS-1:0] cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (32'(cnt_r) == fde_pkg::CMDQ_DEPTH);
  assign valid   = (cnt_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + fde_pkg::CMDQ_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + fde_pkg::CMDQ_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + fde_pkg::CMDQ_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - fde_pkg::CMDQ_CNT_BITS'(1);
      end
    end
  end

endmodule

/* design/fde_back.sv */
// Back end: delay store, gain multipliers, rounding and write-back.
`timescale 1ns / 1ps

module fde_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  fde_pkg::cmd_t                      q_head,
  input  fde_pkg::gains_t                    gains,
  input  logic [fde_pkg::OUTQ_CNT_BITS-1:0]  oq_cnt,
  output logic                               q_pop,
  output logic                               oq_push,
  output fde_pkg::out_item_t                 oq_item
);

  localparam int CRED_BITS = fde_pkg::OUTQ_CNT_BITS + 1;

  // Delay store, one ring per channel.
  logic [fde_pkg::SAMPLE_BITS-1:0] mem [fde_pkg::MEM_DEPTH];
  logic [fde_pkg::SAMPLE_BITS-1:0] rdata_r;

  // Read stage.
  logic          s1_v_r;
  fde_pkg::cmd_t s1_cmd_r;

  // Product stage.
  logic                                 s2_v_r;
  logic signed [fde_pkg::PROD_BITS-1:0] s2_p_dry_r;
  logic signed [fde_pkg::PROD_BITS-1:0] s2_p_wet_r;
  logic signed [fde_pkg::PROD_BITS-1:0] s2_p_fb_r;
  fde_pkg::sample_t                     s2_x_r;
  logic [fde_pkg::ADDR_BITS-1:0]        s2_addr_r;
  logic [fde_pkg::CH_BITS-1:0]          s2_ch_r;
  logic                                 s2_ch_ok_r;

  // Last write, for an item that reads the entry just written.
  logic                            fwd_v_r;
  logic [fde_pkg::ADDR_BITS-1:0]   fwd_addr_r;
  fde_pkg::sample_t                fwd_data_r;

  logic                                 issue;
  logic [CRED_BITS-1:0]                 in_use;
  logic                                 fwd_hit;
  fde_pkg::sample_t                     d;
  logic signed [fde_pkg::ACC_BITS-1:0]  sum_y;
  logic signed [fde_pkg::ACC_BITS-1:0]  sum_w;
  fde_pkg::sample_t                     y;
  fde_pkg::sample_t                     w;
  logic                                 mem_we;

  // Issue only when the read stage is empty and the result has a place.
  assign in_use = CRED_BITS'(oq_cnt) + CRED_BITS'(s1_v_r) + CRED_BITS'(s2_v_r);
  assign issue  = q_valid && !s1_v_r && (32'(in_use) < fde_pkg::OUTQ_DEPTH);
  assign q_pop  = issue;

  // Store read and write-back.
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem[q_head.addr];
    end
    if (mem_we) begin
      mem[s2_addr_r] <= w;
    end
  end

  // Delayed sample: bypass the last write, entries never written read as zero.
  always_comb begin
    fwd_hit = fwd_v_r && (fwd_addr_r == s1_cmd_r.addr);
    if (!s1_cmd_r.ch_ok) begin
      d = '0;
    end else if (fwd_hit) begin
      d = fwd_data_r;
    end else if (s1_cmd_r.written) begin
      d = $signed(rdata_r);
    end else begin
      d = '0;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (mem_we) begin
        fwd_v_r <= 1'b1;
      end
    end
  end

  // Read stage payload and the three gain products.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cmd_r <= q_head;
    end
    if (s1_v_r) begin
      s2_p_dry_r <= gains.dry * s1_cmd_r.x;
      s2_p_wet_r <= gains.wet * d;
      s2_p_fb_r  <= gains.fb * d;
      s2_x_r     <= s1_cmd_r.x;
      s2_addr_r  <= s1_cmd_r.addr;
      s2_ch_r    <= s1_cmd_r.ch;
      s2_ch_ok_r <= s1_cmd_r.ch_ok;
    end
    if (mem_we) begin
      fwd_addr_r <= s2_addr_r;
      fwd_data_r <= w;
    end
  end

  // Mix and write-back sums, each rounded once and saturated.
  always_comb begin
    sum_y = fde_pkg::ACC_BITS'(s2_p_dry_r) + fde_pkg::ACC_BITS'(s2_p_wet_r);
    sum_w = (fde_pkg::ACC_BITS'(s2_x_r) <<< fde_pkg::FRAC_BITS)
          + fde_pkg::ACC_BITS'(s2_p_fb_r);
    y     = fde_pkg::round_sat(sum_y);
    w     = fde_pkg::round_sat(sum_w);
  end

  assign mem_we              = s2_v_r && s2_ch_ok_r;
  assign oq_push             = s2_v_r;
  assign oq_item.sample_out  = y;
  assign oq_item.out_channel = s2_ch_r;

  // An item does not enter the datapath while the one before it is in the read stage.
  a_issue_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> !issue)
    else $error("back end issued on consecutive cycles");

  // A result never arrives at a full output queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (32'(oq_cnt) < fde_pkg::OUTQ_DEPTH))
    else $error("result pushed into a full output queue");

  // Every result comes from an issued item that passed the read and product stages.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> $past(issue, 2))
    else $error("result without a matching issue");

endmodule

/* design/fde_out_queue.sv */
// Output queue holding finished result items until they are popped.
`timescale 1ns / 1ps

module fde_out_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  fde_pkg::out_item_t                 push_item,
  input  logic                               pop,
  output logic                               empty,
  output fde_pkg::out_item_t                 head,
  output logic [fde_pkg::OUTQ_CNT_BITS-1:0]  cnt
);

  fde_pkg::out_item_t                slot_r [fde_pkg::OUTQ_DEPTH];
  logic [fde_pkg::OUTQ_PTR_BITS-1:0] wr_ptr_r;
  logic [fde_pkg::OUTQ_PTR_BITS-1:0] rd_ptr_r;
  logic [fde_pkg::OUTQ_CNT_BITS-1:0] cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign cnt     = cnt_r;
  assign do_push = push && (32'(cnt_r) < fde_pkg::OUTQ_DEPTH);
  assign do_pop  = pop && !empty;

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + fde_pkg::OUTQ_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + fde_pkg::OUTQ_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + fde_pkg::OUTQ_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - fde_pkg::OUTQ_CNT_BITS'(1);
      end
    end
  end

endmodule

/* design/feedback_delay_echo.sv */
// Top level of the multichannel feedback delay echo with its configuration registers.
`timescale 1ns / 1ps

// Multichannel echo: each item carries one sample and its channel. The block reads
// that channel's delay entry, returns dry*x + wet*d, and writes x + feedback*d back.
// Input channel: an item is taken when in_push is high and in_full is low.
// Result channel: out_item holds the oldest result while out_empty is low; it is
// taken when out_pop is high. One result is produced for each item, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 delay length,
// 1 feedback gain, 2 wet level, 3 dry level); write only when idle.
// Path: each item passes the front queue, read stage, product stage and result queue.
// The back end takes a new item only when the one before it has left the read stage,
// and a bypass of the last write lets each store read see the write-back before it.
// A two-entry queue after the front end and a four-entry result queue let both
// sides stall independently; when out_pop stays low the result queue fills, the
// datapath stops issuing and in_full rises once the front queue is full.
// Reset: registers return to their defaults, ring positions go to zero and the
// delay store reads as zero everywhere, tracked by per-channel fill counts; no
// clearing pass is needed and items are accepted right after reset.
module feedback_delay_echo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  fde_pkg::in_item_t                  in_item,
  output logic                               out_empty,
  input  logic                               out_pop,
  output fde_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [fde_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fde_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [fde_pkg::LEN_BITS-1:0] delay_length_r;
  fde_pkg::gain_t               feedback_gain_r;
  fde_pkg::gain_t               wet_level_r;
  fde_pkg::gain_t               dry_level_r;

  logic                               len_wr;
  logic [fde_pkg::LEN_BITS-1:0]       len_eff;
  fde_pkg::gains_t                    gains;
  logic                               cq_push;
  fde_pkg::cmd_t                      cq_in;
  logic                               cq_full;
  logic                               cq_valid;
  fde_pkg::cmd_t                      cq_head;
  logic                               cq_pop;
  logic                               oq_push;
  fde_pkg::out_item_t                 oq_in;
  logic [fde_pkg::OUTQ_CNT_BITS-1:0]  oq_cnt;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_length_r  <= fde_pkg::DELAY_LENGTH_RST;
      feedback_gain_r <= fde_pkg::FEEDBACK_GAIN_RST;
      wet_level_r     <= fde_pkg::WET_LEVEL_RST;
      dry_level_r     <= fde_pkg::DRY_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (fde_pkg::cfg_reg_t'(cfg_index))
        fde_pkg::REG_DELAY_LENGTH: begin
          delay_length_r <= cfg_data[fde_pkg::LEN_BITS-1:0];
        end
        fde_pkg::REG_FEEDBACK_GAIN: begin
          feedback_gain_r <= $signed(cfg_data[fde_pkg::GAIN_BITS-1:0]);
        end
        fde_pkg::REG_WET_LEVEL: begin
          wet_level_r <= $signed(cfg_data[fde_pkg::GAIN_BITS-1:0]);
        end
        fde_pkg::REG_DRY_LEVEL: begin
          dry_level_r <= $signed(cfg_data[fde_pkg::GAIN_BITS-1:0]);
        end
      endcase
    end
  end

  // Settings as the datapath sees them.
  assign len_wr    = cfg_we && (fde_pkg::cfg_reg_t'(cfg_index) == fde_pkg::REG_DELAY_LENGTH);
  assign len_eff   = fde_pkg::eff_length(delay_length_r);
  assign gains.fb  = feedback_gain_r;
  assign gains.wet = wet_level_r;
  assign gains.dry = dry_level_r;
  assign in_full   = cq_full;

  fde_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .q_full  (cq_full),
    .len_eff (len_eff),
    .len_wr  (len_wr),
    .q_push  (cq_push),
    .q_cmd   (cq_in)
  );

  fde_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_in),
    .pop      (cq_pop),
    .full     (cq_full),
    .valid    (cq_valid),
    .head     (cq_head)
  );

  fde_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (cq_valid),
    .q_head  (cq_head),
    .gains   (gains),
    .oq_cnt  (oq_cnt),
    .q_pop   (cq_pop),
    .oq_push (oq_push),
    .oq_item (oq_in)
  );

  fde_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_item (oq_in),
    .pop       (out_pop),
    .empty     (out_empty),
    .head      (out_item),
    .cnt       (oq_cnt)
  );

endmodule
